// File: design/two_tone_goertzel_classifier_assert.svh
// ----------------------------------------------------------------------------
// two-tone goertzel classifier assertion macros
// clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef TWO_TONE_GOERTZEL_CLASSIFIER_ASSERT_SVH
`define TWO_TONE_GOERTZEL_CLASSIFIER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define TTGC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define TTGC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/ttgc_pkg.sv
// ----------------------------------------------------------------------------
// ttgc_pkg
// shared widths, defaults and the window store control types
// ----------------------------------------------------------------------------
package ttgc_pkg;

	localparam int WINDOW_DEF = 16;
	localparam int SHIFT      = 14;

	localparam int SAMPLE_W = 12;
	localparam int COEF_W   = 16;
	localparam int ACC_W    = 32;

	localparam logic signed [COEF_W-1:0] MARK_COEF_RST  = 16'sd23170;
	localparam logic signed [COEF_W-1:0] SPACE_COEF_RST = 16'sd4277;
	localparam logic [SAMPLE_W-1:0]      BIAS_RST       = 12'd2048;

	// read requests into the window store
	typedef struct packed {
		logic start;   // read the oldest entry, restart the read walk
		logic step;    // read the next entry of the walk
	} win_rd_t;

	// window store status
	typedef struct packed {
		logic due;     // the word on the write port completes a window
		logic last;    // the data on the read port is the newest of the window
	} win_stat_t;

endpackage

// File: design/ttgc_window.sv
// ----------------------------------------------------------------------------
// ttgc_window
// ring of the last WINDOW samples with fill count and an oldest-first read walk
// ----------------------------------------------------------------------------
module ttgc_window #(
	parameter int WINDOW = ttgc_pkg::WINDOW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [ttgc_pkg::SAMPLE_W-1:0] wr_sample,
	input  logic                          wr_first,
	input  ttgc_pkg::win_rd_t             rd_ctl,
	output logic [ttgc_pkg::SAMPLE_W-1:0] rd_data,
	output ttgc_pkg::win_stat_t           stat
);

	localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);
	localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(WINDOW);

	logic [ttgc_pkg::SAMPLE_W-1:0] window_mem_q [WINDOW];
	logic [ttgc_pkg::SAMPLE_W-1:0] rd_data_q;
	logic [PTR_W-1:0]              wr_ptr_q;
	logic [PTR_W-1:0]              rd_ptr_q;
	logic [PTR_W-1:0]              rd_cnt_q;
	logic [CNT_W-1:0]              fill_q;

	logic [CNT_W-1:0] fill_base;
	logic [CNT_W-1:0] fill_next;
	logic [PTR_W-1:0] wr_inc;
	logic [PTR_W-1:0] rd_addr;
	logic [PTR_W-1:0] rd_inc;
	logic             rd_en;

	always_comb begin
		fill_base = wr_first ? '0 : fill_q;
		fill_next = (fill_base == FILL_MAX) ? fill_base : fill_base + 1'b1;
		wr_inc    = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
		// after the last write the write pointer sits on the oldest entry
		rd_addr   = rd_ctl.start ? wr_ptr_q : rd_ptr_q;
		rd_inc    = (rd_addr == PTR_LAST) ? '0 : rd_addr + 1'b1;
		rd_en     = rd_ctl.start | rd_ctl.step;
	end

	assign stat.due  = (fill_next == FILL_MAX);
	assign stat.last = (rd_cnt_q == PTR_LAST);
	assign rd_data   = rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			rd_cnt_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_inc;
				fill_q   <= fill_next;
			end
			if (rd_ctl.start) begin
				rd_ptr_q <= rd_inc;
				rd_cnt_q <= '0;
			end else if (rd_ctl.step) begin
				rd_ptr_q <= rd_inc;
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
		end
	end

	// writes only come while the reader is idle, so no same-entry overlap
	always_ff @(posedge clk) begin
		if (wr_en) begin
			window_mem_q[wr_ptr_q] <= wr_sample;
		end
		if (rd_en) begin
			rd_data_q <= window_mem_q[rd_addr];
		end
	end

endmodule

// File: design/two_tone_goertzel_classifier.sv
// ----------------------------------------------------------------------------
// two_tone_goertzel_classifier
// mark/space tone detector: goertzel power of two tones over a sample window
// ----------------------------------------------------------------------------
// input channel: sample and block_first with in_valid/in_stall. a word is taken
// when in_valid is high and in_stall low; block_first restarts the window.
// output channel: tone and total_power with out_valid/out_stall, held while
// out_stall is high. one output register sits between the two channels.
// a sample that does not complete a window gives no word, and the block stays ready for the next sample.
// a sample that completes a window (at least WINDOW samples since the block start)
// starts a run that ends with the result loaded into the output register: one
// shared 32x32 multiplier runs three steps per window entry (mark product,
// space product, write-back) plus ten steps for the two power terms.
// in_stall is high for that whole run; the next sample is taken right after,
// even if the last word still waits in the output register. if the output
// register is still full at the end of a run, the result waits in place.
// config: cfg_we, cfg_index, cfg_data; 0 mark coef, 1 space coef, 2 bias.
// reset clears the fill count (a new block starts), restores the default
// coefficients and bias and empties the output register.
// ----------------------------------------------------------------------------
module two_tone_goertzel_classifier #(
	parameter int WINDOW = ttgc_pkg::WINDOW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ttgc_pkg::SAMPLE_W-1:0] sample,
	input  logic                          block_first,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          tone,
	output logic signed [31:0]            total_power,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [ttgc_pkg::COEF_W-1:0]   cfg_data
);

`include "two_tone_goertzel_classifier_assert.svh"

	typedef enum logic [1:0] {
		REG_MARK  = 2'd0,
		REG_SPACE = 2'd1,
		REG_BIAS  = 2'd2
	} reg_idx_t;

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_RD   = 11'b00000000010,
		S_MM   = 11'b00000000100,
		S_UM   = 11'b00000001000,
		S_US   = 11'b00000010000,
		S_CQ   = 11'b00000100000,
		S_Q11  = 11'b00001000000,
		S_Q22  = 11'b00010000000,
		S_X    = 11'b00100000000,
		S_PW   = 11'b01000000000,
		S_OUT  = 11'b10000000000
	} state_t;

	localparam int AW = ttgc_pkg::ACC_W;
	localparam int CW = ttgc_pkg::COEF_W;
	localparam int SW = ttgc_pkg::SAMPLE_W;

	state_t state_q, state_d;

	logic signed [CW-1:0] mark_coef_q;
	logic signed [CW-1:0] space_coef_q;
	logic [SW-1:0]        bias_q;

	logic signed [AW-1:0]   q1m_q, q2m_q, q1s_q, q2s_q;
	logic signed [AW-1:0]   cq_q, acc_q, pm_q, ps_q;
	logic signed [2*AW-1:0] prod_q;
	logic                   tone_sel_q;
	logic                   out_valid_q;
	logic                   tone_q;
	logic signed [AW-1:0]   total_q;

	ttgc_pkg::win_rd_t   win_rd;
	ttgc_pkg::win_stat_t win_stat;
	logic [SW-1:0]       win_data;

	logic                   in_accept;
	logic                   out_load;
	logic signed [SW:0]     s_diff;
	logic signed [AW-1:0]   s_ext;
	logic signed [2*AW-1:0] prod_sh;
	logic signed [AW-1:0]   cq_now;
	logic signed [AW-1:0]   q0_new;
	logic signed [AW-1:0]   q1_sel, q2_sel;
	logic signed [CW-1:0]   c_sel;
	logic signed [AW-1:0]   mul_a, mul_b;
	logic signed [AW-1:0]   pow;

	ttgc_window #(
		.WINDOW (WINDOW)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (in_accept),
		.wr_sample (sample),
		.wr_first  (block_first),
		.rd_ctl    (win_rd),
		.rd_data   (win_data),
		.stat      (win_stat)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid & ~in_stall;
	assign out_load  = (state_q == S_OUT) & (~out_valid_q | ~out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_coef_q  <= ttgc_pkg::MARK_COEF_RST;
			space_coef_q <= ttgc_pkg::SPACE_COEF_RST;
			bias_q       <= ttgc_pkg::BIAS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MARK:  mark_coef_q  <= cfg_data;
				REG_SPACE: space_coef_q <= cfg_data;
				REG_BIAS:  bias_q       <= cfg_data[SW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		s_diff  = $signed({1'b0, win_data}) - $signed({1'b0, bias_q});
		s_ext   = {{(AW-SW-1){s_diff[SW]}}, s_diff};
		prod_sh = prod_q >>> ttgc_pkg::SHIFT;
		cq_now  = prod_sh[AW-1:0];
		q1_sel  = tone_sel_q ? q1s_q : q1m_q;
		q2_sel  = tone_sel_q ? q2s_q : q2m_q;
		c_sel   = tone_sel_q ? space_coef_q : mark_coef_q;
		// q2 of the tone being updated: mark in S_UM, space in S_US
		q0_new  = cq_now - ((state_q == S_US) ? q2s_q : q2m_q) + s_ext;
		pow     = acc_q - prod_q[AW-1:0];
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MM: begin
				mul_a = {{(AW-CW){mark_coef_q[CW-1]}}, mark_coef_q};
				mul_b = q1m_q;
			end
			S_UM: begin
				mul_a = {{(AW-CW){space_coef_q[CW-1]}}, space_coef_q};
				mul_b = q1s_q;
			end
			S_CQ: begin
				mul_a = {{(AW-CW){c_sel[CW-1]}}, c_sel};
				mul_b = q1_sel;
			end
			S_Q11: begin
				mul_a = q1_sel;
				mul_b = q1_sel;
			end
			S_Q22: begin
				mul_a = q2_sel;
				mul_b = q2_sel;
			end
			S_X: begin
				mul_a = cq_q;
				mul_b = q2_sel;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d      = state_q;
		win_rd.start = 1'b0;
		win_rd.step  = 1'b0;
		unique case (state_q)
			S_IDLE: if (in_valid && win_stat.due) state_d = S_RD;
			S_RD: begin
				win_rd.start = 1'b1;
				state_d      = S_MM;
			end
			S_MM:  state_d = S_UM;
			S_UM:  state_d = S_US;
			S_US: begin
				if (win_stat.last) begin
					state_d = S_CQ;
				end else begin
					win_rd.step = 1'b1;
					state_d     = S_MM;
				end
			end
			S_CQ:  state_d = S_Q11;
			S_Q11: state_d = S_Q22;
			S_Q22: state_d = S_X;
			S_X:   state_d = S_PW;
			S_PW:  state_d = tone_sel_q ? S_OUT : S_CQ;
			S_OUT: if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tone_sel_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_US && win_stat.last) begin
				tone_sel_q <= 1'b0;
			end else if (state_q == S_PW) begin
				tone_sel_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			S_RD: begin
				q1m_q <= '0;
				q2m_q <= '0;
				q1s_q <= '0;
				q2s_q <= '0;
			end
			S_UM: begin
				q1m_q <= q0_new;
				q2m_q <= q1m_q;
			end
			S_US: begin
				q1s_q <= q0_new;
				q2s_q <= q1s_q;
			end
			S_Q11: cq_q  <= cq_now;
			S_Q22: acc_q <= prod_q[AW-1:0];
			S_X:   acc_q <= acc_q + prod_q[AW-1:0];
			S_PW: begin
				if (tone_sel_q) begin
					ps_q <= pow;
				end else begin
					pm_q <= pow;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			tone_q  <= (ps_q > pm_q);
			total_q <= pm_q + ps_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign tone        = tone_q;
	assign total_power = total_q;

	`TTGC_ASSERT_NEXT(a_start_walk, in_accept && win_stat.due, state_q == S_RD, "window walk did not start")
	`TTGC_ASSERT_NEXT(a_walk_end, (state_q == S_US) && win_stat.last, (state_q == S_CQ) && !tone_sel_q, "walk end did not begin mark power")
	`TTGC_ASSERT_NEXT(a_space_done, (state_q == S_PW) && tone_sel_q, state_q == S_OUT, "space power not followed by output")
	`TTGC_ASSERT_NEXT(a_out_load, out_load, out_valid_q && (state_q == S_IDLE), "result load lost")

endmodule

// File: tb/sv/ttgc_tb_pkg.sv
// ----------------------------------------------------------------------------
// ttgc_tb_pkg
// register map of the classifier config port, shared by stimulus and checker
// ----------------------------------------------------------------------------
package ttgc_tb_pkg;

	typedef enum logic [1:0] {
		REG_MARK_COEF  = 2'd0,
		REG_SPACE_COEF = 2'd1,
		REG_BIAS       = 2'd2,
		REG_UNUSED     = 2'd3
	} cfg_reg_t;

endpackage

// File: tb/sv/ttgc_checker.sv
// ----------------------------------------------------------------------------
// ttgc_checker
// watches the sample, result and config ports of the classifier, keeps its
// own window and goertzel predictor, and compares every result word in order
// ----------------------------------------------------------------------------
module ttgc_checker #(
	parameter int WINDOW = ttgc_pkg::WINDOW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [ttgc_pkg::SAMPLE_W-1:0] sample,
	input  logic                          block_first,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic                          tone,
	input  logic signed [31:0]            total_power,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [ttgc_pkg::COEF_W-1:0]   cfg_data,
	output int                            error_count,
	output int                            results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        tone;
		logic [31:0] power;
	} tone_word_t;

	tone_word_t expected_words[$];

	logic [11:0]        sample_ring [WINDOW];
	int                 ring_head;
	int                 block_fill;
	logic signed [15:0] mark_coef;
	logic signed [15:0] space_coef;
	logic [11:0]        dc_offset;

	int errors = 0;
	int due = 0;

	assign error_count = errors;
	assign results_due = due;

	task automatic report(string msg);
		if (errors < 50)
			$display("%0t ttgc_checker: %s", $time, msg);
		errors++;
	endtask

	// (c * q) >>> SHIFT, kept to 32 bits
	function automatic logic [31:0] coef_product(logic signed [15:0] c, logic [31:0] q);
		logic signed [63:0] p;
		logic signed [63:0] r;
		p = $signed({{48{c[15]}}, c}) * $signed({{32{q[31]}}, q});
		r = p >>> ttgc_pkg::SHIFT;
		return r[31:0];
	endfunction

	// recurrence runs oldest sample first; ring_head points at the oldest
	function automatic logic [31:0] goertzel_energy(logic signed [15:0] c);
		logic [31:0] q0;
		logic [31:0] q1;
		logic [31:0] q2;
		logic [31:0] s;
		int pos;
		q1 = '0;
		q2 = '0;
		pos = ring_head;
		for (int i = 0; i < WINDOW; i++) begin
			s = {20'd0, sample_ring[pos]} - {20'd0, dc_offset};
			q0 = coef_product(c, q1) - q2 + s;
			q2 = q1;
			q1 = q0;
			pos = (pos + 1) % WINDOW;
		end
		return q1 * q1 + q2 * q2 - coef_product(c, q1) * q2;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		tone_word_t  want;
		logic [31:0] mark_energy;
		logic [31:0] space_energy;
		if (!arst_n) begin
			mark_coef = ttgc_pkg::MARK_COEF_RST;
			space_coef = ttgc_pkg::SPACE_COEF_RST;
			dc_offset = ttgc_pkg::BIAS_RST;
			block_fill = 0;
			ring_head = 0;
			expected_words.delete();
			due = 0;
		end else begin
			// a result can never leave in the cycle its sample is taken, so pop first
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					report($sformatf("unexpected word tone=%0b power=%0d", tone, total_power));
				end else begin
					want = expected_words.pop_front();
					if (tone !== want.tone)
						report($sformatf("tone %0b, predicted %0b", tone, want.tone));
					if (total_power !== want.power)
						report($sformatf("total_power %0d, predicted %0d",
							total_power, $signed(want.power)));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					ttgc_tb_pkg::REG_MARK_COEF: begin
						mark_coef = cfg_data;
					end
					ttgc_tb_pkg::REG_SPACE_COEF: begin
						space_coef = cfg_data;
					end
					ttgc_tb_pkg::REG_BIAS: begin
						dc_offset = cfg_data[11:0];
					end
					default: begin
					end
				endcase
			end
			if (in_valid && !in_stall) begin
				if (block_first)
					block_fill = 0;
				sample_ring[ring_head] = sample;
				ring_head = (ring_head + 1) % WINDOW;
				if (block_fill < WINDOW)
					block_fill++;
				if (block_fill == WINDOW) begin
					mark_energy = goertzel_energy(mark_coef);
					space_energy = goertzel_energy(space_coef);
					want.tone = $signed(space_energy) > $signed(mark_energy);
					want.power = mark_energy + space_energy;
					expected_words.push_back(want);
				end
			end
			due = expected_words.size();
		end
	end

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives sample blocks and register settings into the two-tone classifier
// with random gaps and back-pressure; the checker beside it judges the results
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW         = ttgc_pkg::WINDOW_DEF;
	localparam int DRAIN          = 3 * WINDOW + 16;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASES         = 12;
	localparam int PHASE_ITEMS    = 75;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [ttgc_pkg::SAMPLE_W-1:0] sample;
	logic                          block_first;
	logic                          out_valid;
	logic                          out_stall;
	logic                          tone;
	logic signed [31:0]            total_power;
	logic                          cfg_we;
	logic [1:0]                    cfg_index;
	logic [ttgc_pkg::COEF_W-1:0]   cfg_data;

	int error_count;
	int results_due;
	int hold_cycles = 0;
	bit idle_on = 1'b1;

	two_tone_goertzel_classifier #(
		.WINDOW(WINDOW)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.block_first(block_first),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tone(tone),
		.total_power(total_power),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	ttgc_checker #(
		.WINDOW(WINDOW)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.block_first(block_first),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tone(tone),
		.total_power(total_power),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.error_count(error_count),
		.results_due(results_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		out_stall <= idle_on && ($urandom_range(0, 99) < 11);
	end

	// nothing moving on either channel for too long means a hang
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			hold_cycles <= 0;
		else
			hold_cycles <= hold_cycles + 1;
		if (hold_cycles >= WATCHDOG_LIMIT) begin
			$display("[two_tone_goertzel_classifier] ERROR");
			$finish;
		end
	end

	task automatic send_sample(logic [11:0] s, logic bf);
		while (idle_on && $urandom_range(0, 99) < 11) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		block_first <= bf;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// wait for every result word, then let a running window pass finish
	task automatic settle();
		in_valid <= 1'b0;
		while (results_due != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic write_reg(ttgc_tb_pkg::cfg_reg_t idx, logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
	endtask

	task automatic program_registers(logic [15:0] mark, logic [15:0] space,
			logic [15:0] bias, bit poke_unused);
		settle();
		write_reg(ttgc_tb_pkg::REG_MARK_COEF, mark);
		write_reg(ttgc_tb_pkg::REG_SPACE_COEF, space);
		write_reg(ttgc_tb_pkg::REG_BIAS, bias);
		if (poke_unused)
			write_reg(ttgc_tb_pkg::REG_UNUSED, 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		logic [11:0] v;
		int sent;
		int len;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		block_first = 1'b0;
		cfg_we = 1'b0;
		cfg_index = ttgc_tb_pkg::REG_MARK_COEF;
		cfg_data = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset opens a block by itself: a full window with no block_first
		for (int i = 0; i < WINDOW + 1; i++) begin
			case (i % 7)
				0: v = 12'd0;
				1: v = 12'd4095;
				2: v = 12'd2048;
				3: v = 12'd1;
				4: v = 12'd4094;
				5: v = 12'h555;
				default: v = 12'hAAA;
			endcase
			send_sample(v, 1'b0);
		end
		// short block, no word expected from it
		for (int i = 0; i < 6; i++)
			send_sample(12'd4095 - 12'(i), i == 0);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: program_registers(16'h7FFF, 16'h8000, 16'd0, 1'b0);
				1: program_registers(16'h8000, 16'h7FFF, 16'd4095, 1'b1);
				2: program_registers(16'd0, 16'd0, 16'hF800, 1'b0);
				3: program_registers(16'd1, 16'hFFFF, 16'd4095, 1'b0);
				default: program_registers(16'($urandom), 16'($urandom), 16'($urandom),
					1'($urandom_range(0, 1)));
			endcase
			idle_on = (ph != 3);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0)
					len = $urandom_range(1, WINDOW - 1);
				else
					len = $urandom_range(WINDOW, 3 * WINDOW);
				for (int i = 0; i < len && sent < PHASE_ITEMS; i++) begin
					case ($urandom_range(0, 3))
						0, 1: v = 12'($urandom_range(0, 4095));
						2: v = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
						default: v = 12'($urandom_range(1984, 2111));
					endcase
					send_sample(v, i == 0);
					sent++;
					// sender holds off mid-block until the pipe is empty
					if (ph == 5 && sent == PHASE_ITEMS / 2)
						settle();
				end
			end
		end

		settle();
		if (error_count == 0)
			$display("[two_tone_goertzel_classifier] OK");
		else
			$display("[two_tone_goertzel_classifier] ERROR");
		$finish;
	end

endmodule
